@@ hw/rtl/vwlc_pkg.sv @@
// ----------------------------------------------------------------------------
// vwlc_pkg
// Shared widths, register indexes and reset values for the vote window
// lockout controller and its port checker.
// ----------------------------------------------------------------------------
`default_nettype none

package vwlc_pkg;

  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [SCORE_W-1:0]    score_t;
  typedef logic [TICK_W-1:0]     tick_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // configuration register indexes
  localparam cfg_idx_t CFG_SCORE_THRESHOLD  = 2'd0;
  localparam cfg_idx_t CFG_LOCKOUT_TICKS    = 2'd1;
  localparam cfg_idx_t CFG_MATCH_WAIT_TICKS = 2'd2;

  // reset values, threshold is 0.8 in Q1.15
  localparam score_t RST_SCORE_THRESHOLD  = 16'd26214;
  localparam tick_t  RST_LOCKOUT_TICKS    = 16'd30;
  localparam tick_t  RST_MATCH_WAIT_TICKS = 16'd30;

  localparam tick_t TICK_MAX = '1;

  // item kinds
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_FRAME = 1'b1;

endpackage

`default_nettype wire

@@ hw/rtl/vote_window_lockout_controller_unit.sv @@
// ----------------------------------------------------------------------------
// vote_window_lockout_controller_unit
// Door lock controller driven by time ticks and camera frame reports: votes
// on match scores over a window, unlocks on enough passes, else locks out.
// ----------------------------------------------------------------------------
// The block takes one item (tick or frame report) every clock cycle unless
// out_stall holds it back, and returns exactly one status result for each.
// An accepted item sits in an input register, is evaluated by a single
// layer of compare and counter logic, and its result is then registered in
// the output register, so sustained throughput is one item per cycle while
// out_stall is low. The output register and the input register are the
// only places an item waits; the input side stalls only while both are
// full and the result is held by out_stall. Votes of a window are kept as
// a running pass count, so the window tally costs one small add per frame.
// Configuration writes are always accepted (cfg_ready is tied high) and
// should be made while the block is idle.
`default_nettype none

module vote_window_lockout_controller_unit #(
  parameter int unsigned WINDOW_SIZE = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration write port
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire vwlc_pkg::cfg_idx_t   cfg_index,
  input  wire vwlc_pkg::cfg_data_t  cfg_data,
  // input items
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_func,
  input  wire logic                 in_frame_matchable,
  input  wire logic                 in_matchable_error,
  input  wire logic                 in_score_error,
  input  wire vwlc_pkg::score_t     in_match_score,
  // result items
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_door_locked,
  output logic                      out_in_lockout,
  output logic                      out_match_waiting,
  output logic                      out_vote_recorded,
  output logic                      out_window_done,
  output logic                      out_window_passed
);

  import vwlc_pkg::*;

  localparam int unsigned IDX_W = $clog2(WINDOW_SIZE);
  localparam int unsigned CNT_W = $clog2(WINDOW_SIZE + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(WINDOW_SIZE - 1);
  localparam logic [CNT_W-1:0] PASS_NEED = CNT_W'(WINDOW_SIZE - 2);

  // configuration
  score_t score_thr_r;
  tick_t  lockout_ticks_r;
  tick_t  wait_ticks_r;

  // input register
  logic   s1_valid_r;
  logic   s1_func_r;
  logic   s1_matchable_r;
  logic   s1_m_err_r;
  logic   s1_s_err_r;
  score_t s1_score_r;

  // block state
  logic             lockout_r, lockout_nxt;
  logic             door_r, door_nxt;
  logic             waiting_r, waiting_nxt;
  tick_t            lock_cnt_r, lock_cnt_nxt;
  tick_t            wait_cnt_r, wait_cnt_nxt;
  logic [IDX_W-1:0] vote_idx_r, vote_idx_nxt;
  logic [CNT_W-1:0] pass_cnt_r, pass_cnt_nxt;

  // result register
  logic out_valid_r;
  logic door_out_r, lockout_out_r, waiting_out_r;
  logic recorded_r, done_r, passed_r;

  logic             s1_adv;
  logic             in_acc;
  logic             do_step;
  logic             recorded, done, passed;
  logic             vote;
  logic             wait_over;
  logic [CNT_W-1:0] pass_sum;

  assign cfg_ready = 1'b1;

  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign do_step  = s1_valid_r && s1_adv;

  assign vote      = (s1_score_r >= score_thr_r);
  assign wait_over = (wait_cnt_r >= wait_ticks_r);
  assign pass_sum  = pass_cnt_r + CNT_W'(vote);

  always_comb begin
    lockout_nxt  = lockout_r;
    door_nxt     = door_r;
    waiting_nxt  = waiting_r;
    lock_cnt_nxt = lock_cnt_r;
    wait_cnt_nxt = wait_cnt_r;
    vote_idx_nxt = vote_idx_r;
    pass_cnt_nxt = pass_cnt_r;
    recorded     = 1'b0;
    done         = 1'b0;
    passed       = 1'b0;

    if (s1_func_r == FUNC_TICK) begin
      // running timers count up and stick at full scale
      if (lockout_r && lock_cnt_r != TICK_MAX) begin
        lock_cnt_nxt = lock_cnt_r + 1'b1;
      end
      if (waiting_r && wait_cnt_r != TICK_MAX) begin
        wait_cnt_nxt = wait_cnt_r + 1'b1;
      end
    end else if (lockout_r) begin
      if (lock_cnt_r >= lockout_ticks_r) begin
        lockout_nxt = 1'b0;
        door_nxt    = 1'b0;
      end
    end else if (!s1_m_err_r) begin
      if (waiting_r && wait_over) begin
        waiting_nxt = 1'b0;
      end
      if (s1_matchable_r && !s1_s_err_r && (!waiting_r || wait_over)) begin
        recorded = 1'b1;
        if (vote_idx_r == LAST_IDX) begin
          done         = 1'b1;
          vote_idx_nxt = '0;
          pass_cnt_nxt = '0;
          if (pass_sum >= PASS_NEED) begin
            passed       = 1'b1;
            door_nxt     = 1'b0;
            waiting_nxt  = 1'b1;
            wait_cnt_nxt = '0;
          end else begin
            // zero lockout time leaves the door open
            door_nxt     = (lockout_ticks_r != '0);
            lockout_nxt  = 1'b1;
            lock_cnt_nxt = '0;
            waiting_nxt  = 1'b0;
          end
        end else begin
          vote_idx_nxt = vote_idx_r + 1'b1;
          pass_cnt_nxt = pass_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_thr_r     <= RST_SCORE_THRESHOLD;
      lockout_ticks_r <= RST_LOCKOUT_TICKS;
      wait_ticks_r    <= RST_MATCH_WAIT_TICKS;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      lockout_r       <= 1'b0;
      door_r          <= 1'b0;
      waiting_r       <= 1'b0;
      lock_cnt_r      <= '0;
      wait_cnt_r      <= '0;
      vote_idx_r      <= '0;
      pass_cnt_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_SCORE_THRESHOLD:  score_thr_r     <= cfg_data;
          CFG_LOCKOUT_TICKS:    lockout_ticks_r <= cfg_data;
          CFG_MATCH_WAIT_TICKS: wait_ticks_r    <= cfg_data;
          default: ;
        endcase
      end

      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (do_step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (do_step) begin
        lockout_r  <= lockout_nxt;
        door_r     <= door_nxt;
        waiting_r  <= waiting_nxt;
        lock_cnt_r <= lock_cnt_nxt;
        wait_cnt_r <= wait_cnt_nxt;
        vote_idx_r <= vote_idx_nxt;
        pass_cnt_r <= pass_cnt_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_func_r      <= in_func;
      s1_matchable_r <= in_frame_matchable;
      s1_m_err_r     <= in_matchable_error;
      s1_s_err_r     <= in_score_error;
      s1_score_r     <= in_match_score;
    end
    if (do_step) begin
      door_out_r    <= door_nxt;
      lockout_out_r <= lockout_nxt;
      waiting_out_r <= waiting_nxt;
      recorded_r    <= recorded;
      done_r        <= done;
      passed_r      <= passed;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_door_locked   = door_out_r;
  assign out_in_lockout    = lockout_out_r;
  assign out_match_waiting = waiting_out_r;
  assign out_vote_recorded = recorded_r;
  assign out_window_done   = done_r;
  assign out_window_passed = passed_r;

endmodule

`default_nettype wire

@@ hw/rtl/vwlc_checker.sv @@
// ----------------------------------------------------------------------------
// vwlc_checker
// Port-level checks on the vote window lockout controller, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vwlc_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire logic out_door_locked,
  input wire logic out_in_lockout,
  input wire logic out_match_waiting,
  input wire logic out_vote_recorded,
  input wire logic out_window_done,
  input wire logic out_window_passed
);

  import vwlc_pkg::*;

  // a held result keeps its status
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_door_locked)
      && $stable(out_in_lockout) && $stable(out_window_done))
    else $error("stalled result changed");

  // a window completes only on a recorded vote, and passes only when complete
  a_window_vote: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_done |-> out_vote_recorded)
    else $error("window done without a vote");

  a_pass_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_window_passed |-> out_window_done && out_match_waiting
      && !out_in_lockout && !out_door_locked)
    else $error("passed window left wrong state");

  // lockout and match wait never run together, and a locked door means lockout
  a_modes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_in_lockout && out_match_waiting)
      && (!out_door_locked || out_in_lockout))
    else $error("inconsistent lockout and wait status");

endmodule

bind vote_window_lockout_controller_unit vwlc_checker u_vwlc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_door_locked   (out_door_locked),
  .out_in_lockout    (out_in_lockout),
  .out_match_waiting (out_match_waiting),
  .out_vote_recorded (out_vote_recorded),
  .out_window_done   (out_window_done),
  .out_window_passed (out_window_passed)
);

`default_nettype wire
